>>> sv/gdft_pkg.sv
// shared constants and codes for the depth-first graph traversal block
// no dependencies; imported by the channel interfaces and the top level
`timescale 1ns / 1ps
`default_nettype none

package gdft_pkg;

   // vertex number width is fixed by the word format
   localparam int VERTEX_W = 6;
   localparam int VERTICES = 1 << VERTEX_W;

   // edge pool; a pointer carries one extra bit so that null fits
   localparam int EDGES    = 256;
   localparam int EIDX_W   = $clog2(EDGES);
   localparam int EPTR_W   = EIDX_W + 1;
   localparam logic [EPTR_W-1:0] NIL_EDGE = EPTR_W'(EDGES);

   // request opcodes
   localparam logic OP_ADD_EDGE = 1'b0;
   localparam logic OP_TRAVERSE = 1'b1;

   // response status codes
   localparam logic ST_VISITED    = 1'b0;
   localparam logic ST_TABLE_FULL = 1'b1;

endpackage

`default_nettype wire

>>> sv/gdft_if.sv
// valid/ready channel interfaces: request, response and register write
// depends on gdft_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface gdft_req_if
   import gdft_pkg::*;
   ;
   logic                valid;
   logic                ready;
   logic                op;
   logic [VERTEX_W-1:0] from_vertex;
   logic [VERTEX_W-1:0] to_vertex;

   modport source (output valid, op, from_vertex, to_vertex, input ready);
   modport sink   (input valid, op, from_vertex, to_vertex, output ready);
endinterface

interface gdft_rsp_if
   import gdft_pkg::*;
   ;
   logic                valid;
   logic                ready;
   logic [VERTEX_W-1:0] vertex;
   logic                status;
   logic                last;

   modport source (output valid, vertex, status, last, input ready);
   modport sink   (input valid, vertex, status, last, output ready);
endinterface

interface gdft_csr_if;
   logic valid;
   logic ready;
   logic undirected;

   modport source (output valid, undirected, input ready);
   modport sink   (input valid, undirected, output ready);
endinterface

`default_nettype wire

>>> sv/graph_depth_first_traversal.sv
// depth-first graph traversal: edge pool with per-vertex adjacency lists,
// explicit cursor stack and a single sequencer; uses gdft_pkg and gdft_if
//
//   channel | dir | word                          | accepted when
//   req     | in  | op, from_vertex, to_vertex    | req.valid & req.ready
//   rsp     | out | vertex, status, last          | rsp.valid & rsp.ready
//   csr     | in  | undirected                    | csr.valid & csr.ready
//
// an edge is stored by a tail read and an append, plus a link step if its list was not
// empty; undirected repeats these for the reversed copy. a full table answers from a
// state of its own. a traversal moves through head, step, edge and pop states on the
// registered reads of the edge pool and stack memories; req is held off meanwhile.
// reset clears lists, marks and the edge count at once; no clearing pass.
// rsp has a one-word output register; a stall holds only a new word's handover
`timescale 1ns / 1ps
`default_nettype none

module graph_depth_first_traversal
   import gdft_pkg::*;
(
   input  wire       clock,
   input  wire       reset,
   gdft_req_if.sink  req,
   gdft_rsp_if.source rsp,
   gdft_csr_if.sink  csr
);

   typedef enum logic [9:0] {
      S_IDLE    = 10'b0000000001,
      S_FULL    = 10'b0000000010,
      S_TAIL_RD = 10'b0000000100,
      S_APPEND  = 10'b0000001000,
      S_LINK    = 10'b0000010000,
      S_HEAD    = 10'b0000100000,
      S_STEP    = 10'b0001000000,
      S_EDGE    = 10'b0010000000,
      S_POP     = 10'b0100000000,
      S_DONE    = 10'b1000000000
   } state_type;

   // control registers
   state_type            state_ff, state_in;
   logic                 undirected_ff, undirected_in;
   logic [EPTR_W-1:0]    edges_used_ff, edges_used_in;
   logic [VERTICES-1:0]  used_ff, used_in;
   logic [VERTICES-1:0]  seen_ff, seen_in;
   logic                 second_ff, second_in;
   logic [VERTEX_W-1:0]  top_ff, top_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // working payload registers
   logic [VERTEX_W-1:0]  src_ff, src_in;
   logic [VERTEX_W-1:0]  dst_ff, dst_in;
   logic [EPTR_W-1:0]    cur_ff, cur_in;
   logic [VERTEX_W-1:0]  pend_ff, pend_in;
   logic [VERTEX_W-1:0]  rsp_vertex_ff, rsp_vertex_in;
   logic                 rsp_status_ff, rsp_status_in;
   logic                 rsp_last_ff, rsp_last_in;

   // memories and their registered read data
   logic [VERTEX_W-1:0]  tgt_mem  [EDGES];
   logic [EPTR_W-1:0]    link_mem [EDGES];
   logic [EPTR_W-1:0]    head_mem [VERTICES];
   logic [EPTR_W-1:0]    tail_mem [VERTICES];
   logic [EPTR_W-1:0]    stk_mem  [VERTICES];
   logic [VERTEX_W-1:0]  tgt_q_ff;
   logic [EPTR_W-1:0]    link_q_ff;
   logic [EPTR_W-1:0]    head_q_ff;
   logic                 head_ok_ff;
   logic [EPTR_W-1:0]    tail_q_ff;
   logic [EPTR_W-1:0]    stk_q_ff;

   // memory control
   logic                 pool_wr;
   logic                 link_wr;
   logic [EIDX_W-1:0]    link_wr_addr;
   logic [EPTR_W-1:0]    link_wr_data;
   logic                 list_wr;
   logic                 head_wr;
   logic                 stk_wr;
   logic [VERTEX_W-1:0]  head_rd_addr;
   logic [VERTEX_W-1:0]  stk_rd_addr;

   logic                 req_take;
   logic                 slot_free;
   logic                 emit;
   logic [VERTEX_W-1:0]  emit_vertex;
   logic                 emit_status;
   logic                 emit_last;
   logic [EPTR_W:0]      need_sum;
   logic                 table_full;

   assign req.ready   = (state_ff == S_IDLE);
   assign req_take    = req.valid && req.ready;
   assign csr.ready   = 1'b1;
   assign slot_free   = !rsp_valid_ff || rsp.ready;

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.vertex  = rsp_vertex_ff;
   assign rsp.status  = rsp_status_ff;
   assign rsp.last    = rsp_last_ff;

   // free slots needed: two when each edge is stored both ways
   assign need_sum    = {1'b0, edges_used_ff} + (undirected_ff ? (EPTR_W+1)'(2)
                                                               : (EPTR_W+1)'(1));
   assign table_full  = need_sum > (EPTR_W+1)'(EDGES);

   assign head_rd_addr = (state_ff == S_EDGE) ? tgt_q_ff : req.from_vertex;
   assign stk_rd_addr  = top_ff - VERTEX_W'(1);

   always_comb begin
      state_in      = state_ff;
      undirected_in = csr.valid ? csr.undirected : undirected_ff;
      edges_used_in = edges_used_ff;
      used_in       = used_ff;
      seen_in       = seen_ff;
      second_in     = second_ff;
      top_in        = top_ff;
      src_in        = src_ff;
      dst_in        = dst_ff;
      cur_in        = cur_ff;
      pend_in       = pend_ff;
      emit          = 1'b0;
      emit_vertex   = pend_ff;
      emit_status   = ST_VISITED;
      emit_last     = 1'b0;
      pool_wr       = 1'b0;
      link_wr       = 1'b0;
      link_wr_addr  = edges_used_ff[EIDX_W-1:0];
      link_wr_data  = NIL_EDGE;
      list_wr       = 1'b0;
      head_wr       = 1'b0;
      stk_wr        = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               src_in    = req.from_vertex;
               dst_in    = req.to_vertex;
               second_in = 1'b0;
               if (req.op == OP_TRAVERSE) begin
                  // fresh marks with the start vertex already seen
                  seen_in                  = '0;
                  seen_in[req.from_vertex] = 1'b1;
                  pend_in                  = req.from_vertex;
                  top_in                   = '0;
                  state_in                 = S_HEAD;
               end else if (table_full) begin
                  state_in = S_FULL;
               end else begin
                  state_in = S_TAIL_RD;
               end
            end
         end

         S_FULL: begin
            if (slot_free) begin
               emit        = 1'b1;
               emit_vertex = '0;
               emit_status = ST_TABLE_FULL;
               emit_last   = 1'b1;
               state_in    = S_IDLE;
            end
         end

         S_TAIL_RD: begin
            state_in = S_APPEND;
         end

         S_APPEND: begin
            pool_wr         = 1'b1;
            link_wr         = 1'b1;
            list_wr         = 1'b1;
            head_wr         = !used_ff[src_ff];
            used_in[src_ff] = 1'b1;
            edges_used_in   = edges_used_ff + EPTR_W'(1);
            if (used_ff[src_ff]) begin
               state_in = S_LINK;
            end else if (undirected_ff && !second_ff) begin
               src_in    = dst_ff;
               dst_in    = src_ff;
               second_in = 1'b1;
               state_in  = S_TAIL_RD;
            end else begin
               state_in = S_IDLE;
            end
         end

         S_LINK: begin
            // chain the old tail to the slot just filled
            link_wr      = 1'b1;
            link_wr_addr = tail_q_ff[EIDX_W-1:0];
            link_wr_data = edges_used_ff - EPTR_W'(1);
            if (undirected_ff && !second_ff) begin
               src_in    = dst_ff;
               dst_in    = src_ff;
               second_in = 1'b1;
               state_in  = S_TAIL_RD;
            end else begin
               state_in = S_IDLE;
            end
         end

         S_HEAD: begin
            cur_in   = head_ok_ff ? head_q_ff : NIL_EDGE;
            state_in = S_STEP;
         end

         S_STEP: begin
            if (cur_ff == NIL_EDGE) begin
               if (top_ff == '0) begin
                  state_in = S_DONE;
               end else begin
                  top_in   = top_ff - VERTEX_W'(1);
                  state_in = S_POP;
               end
            end else begin
               state_in = S_EDGE;
            end
         end

         S_EDGE: begin
            if (seen_ff[tgt_q_ff]) begin
               cur_in   = link_q_ff;
               state_in = S_STEP;
            end else if (slot_free) begin
               // previous vertex is not the final one, hand it over
               emit              = 1'b1;
               pend_in           = tgt_q_ff;
               seen_in[tgt_q_ff] = 1'b1;
               stk_wr            = 1'b1;
               top_in            = top_ff + VERTEX_W'(1);
               state_in          = S_HEAD;
            end
         end

         S_POP: begin
            cur_in   = stk_q_ff;
            state_in = S_STEP;
         end

         S_DONE: begin
            if (slot_free) begin
               emit      = 1'b1;
               emit_last = 1'b1;
               state_in  = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_vertex_in = rsp_vertex_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      if (emit) begin
         rsp_valid_in  = 1'b1;
         rsp_vertex_in = emit_vertex;
         rsp_status_in = emit_status;
         rsp_last_in   = emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         undirected_ff <= 1'b0;
         edges_used_ff <= '0;
         used_ff       <= '0;
         seen_ff       <= '0;
         second_ff     <= 1'b0;
         top_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         undirected_ff <= undirected_in;
         edges_used_ff <= edges_used_in;
         used_ff       <= used_in;
         seen_ff       <= seen_in;
         second_ff     <= second_in;
         top_ff        <= top_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff        <= src_in;
      dst_ff        <= dst_in;
      cur_ff        <= cur_in;
      pend_ff       <= pend_in;
      rsp_vertex_ff <= rsp_vertex_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // edge pool: target and next-edge link
   always_ff @(posedge clock) begin
      if (pool_wr) begin
         tgt_mem[edges_used_ff[EIDX_W-1:0]] <= dst_ff;
      end
      tgt_q_ff <= tgt_mem[cur_ff[EIDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (link_wr) begin
         link_mem[link_wr_addr] <= link_wr_data;
      end
      link_q_ff <= link_mem[cur_ff[EIDX_W-1:0]];
   end

   // list heads and tails, valid only where used_ff is set
   always_ff @(posedge clock) begin
      if (head_wr) begin
         head_mem[src_ff] <= edges_used_ff;
      end
      head_q_ff  <= head_mem[head_rd_addr];
      head_ok_ff <= used_ff[head_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (list_wr) begin
         tail_mem[src_ff] <= edges_used_ff;
      end
      tail_q_ff <= tail_mem[src_ff];
   end

   // saved cursors of the frames below the top
   always_ff @(posedge clock) begin
      if (stk_wr) begin
         stk_mem[top_ff] <= link_q_ff;
      end
      stk_q_ff <= stk_mem[stk_rd_addr];
   end

endmodule

`default_nettype wire

>>> tb/graph_depth_first_traversal_tb.sv
// self-checking bench for the depth-first graph traversal block: edge loads and walks
// depend on gdft_pkg and the gdft_req_if / gdft_rsp_if / gdft_csr_if channel interfaces
// expected visit order comes from an adjacency-list model kept inside this bench
`timescale 1ns / 1ps

module graph_depth_first_traversal_tb;
   import gdft_pkg::*;

   localparam int MAX_VISITS    = 64;
   localparam int SETTLE_CYCLES = 2 * EDGES + 3 * VERTICES + 64;
   localparam int LONG_HOLD     = 500;

   typedef struct packed {
      logic                op;
      logic [VERTEX_W-1:0] src;
      logic [VERTEX_W-1:0] dst;
   } graph_op_type;

   typedef struct packed {
      logic [VERTEX_W-1:0] vertex;
      logic                status;
      logic                last;
   } visit_word_type;

   logic clock;
   logic reset;

   gdft_req_if req_bus ();
   gdft_rsp_if rsp_bus ();
   gdft_csr_if csr_bus ();

   graph_depth_first_traversal DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus),
      .csr   (csr_bus)
   );

   // graph image: edge pool plus per-vertex list ends
   logic [VERTEX_W-1:0] pool_target [EDGES];
   logic [EPTR_W-1:0]   pool_link   [EDGES];
   logic [EPTR_W-1:0]   list_first  [VERTICES];
   logic [EPTR_W-1:0]   list_last   [VERTICES];
   int                  edge_count;
   bit                  mode_undirected;

   graph_op_type   ops_pending [$];
   visit_word_type visits_due  [$];

   int gap_pct;
   int stall_pct;
   logic long_hold_start;
   int hold_left;

   int ops_accepted;
   int edge_loads;
   int table_full_hits;
   int walks;
   int longest_walk;
   int words_checked;
   int fail_count;

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic void link_edge(input logic [VERTEX_W-1:0] src,
                                     input logic [VERTEX_W-1:0] dst);
      logic [EIDX_W-1:0] slot;
      slot = EIDX_W'(edge_count);
      pool_target[slot] = dst;
      pool_link[slot]   = NIL_EDGE;
      if (list_last[src] == NIL_EDGE) begin
         list_first[src] = {1'b0, slot};
      end else begin
         pool_link[list_last[src][EIDX_W-1:0]] = {1'b0, slot};
      end
      list_last[src] = {1'b0, slot};
      edge_count++;
   endfunction

   function automatic void walk_from(input logic [VERTEX_W-1:0] start);
      logic [EPTR_W-1:0]   cursor [VERTICES];
      logic [VERTEX_W-1:0] order [$];
      bit [VERTICES-1:0]   seen;
      logic [EPTR_W-1:0]   cur;
      logic [VERTEX_W-1:0] dst;
      int                  depth;
      visit_word_type      word;
      seen = '0;
      seen[start] = 1'b1;
      order.insert(order.size(), start);
      cursor[0] = list_first[start];
      depth = 1;
      while (depth > 0) begin
         cur = cursor[depth-1];
         if (cur >= EDGES) begin
            depth--;
         end else begin
            dst = pool_target[cur[EIDX_W-1:0]];
            cursor[depth-1] = pool_link[cur[EIDX_W-1:0]];
            if (!seen[dst] && depth < VERTICES && order.size() < MAX_VISITS) begin
               seen[dst] = 1'b1;
               order.insert(order.size(), dst);
               cursor[depth] = list_first[dst];
               depth++;
            end
         end
      end
      foreach (order[k]) begin
         word = '{vertex: order[k], status: ST_VISITED, last: (k == order.size() - 1)};
         visits_due.insert(visits_due.size(), word);
      end
      if (order.size() > longest_walk) longest_walk = order.size();
   endfunction

   function automatic void predict_graph_op(input graph_op_type op);
      int             need;
      visit_word_type word;
      ops_accepted++;
      if (op.op == OP_ADD_EDGE) begin
         edge_loads++;
         need = mode_undirected ? 2 : 1;
         if (EDGES - edge_count < need) begin
            table_full_hits++;
            word = '{vertex: '0, status: ST_TABLE_FULL, last: 1'b1};
            visits_due.insert(visits_due.size(), word);
         end else begin
            link_edge(op.src, op.dst);
            if (mode_undirected) link_edge(op.dst, op.src);
         end
      end else begin
         walks++;
         walk_from(op.src);
      end
   endfunction

   function automatic void queue_op(input logic op, input logic [VERTEX_W-1:0] src,
                                    input logic [VERTEX_W-1:0] dst);
      graph_op_type item;
      item = '{op: op, src: src, dst: dst};
      ops_pending.insert(ops_pending.size(), item);
   endfunction

   // a quarter of the picks land in a small cluster so lists get dense
   function automatic logic [VERTEX_W-1:0] pick_vertex();
      if ($urandom_range(0, 3) == 0) return VERTEX_W'($urandom_range(0, 7));
      return VERTEX_W'($urandom_range(0, VERTICES - 1));
   endfunction

   task automatic queue_mix(input int budget);
      int n, r, k;
      logic [VERTEX_W-1:0] head, a, b;
      n = 0;
      while (n < budget) begin
         r = $urandom_range(0, 99);
         if (r < 10) begin
            // short path, then a walk from its head
            k = $urandom_range(2, 5);
            head = pick_vertex();
            a = head;
            repeat (k) begin
               b = pick_vertex();
               queue_op(OP_ADD_EDGE, a, b);
               a = b;
            end
            queue_op(OP_TRAVERSE, head, VERTEX_W'($urandom));
            n += k + 1;
         end else if (r < 25) begin
            queue_op(OP_ADD_EDGE, pick_vertex(), pick_vertex());
            n++;
         end else begin
            queue_op(OP_TRAVERSE, pick_vertex(), VERTEX_W'($urandom));
            n++;
         end
      end
   endtask

   task automatic wait_drain();
      do @(negedge clock);
      while (ops_pending.size() != 0 || req_bus.valid || visits_due.size() != 0);
   endtask

   task automatic settle();
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_mode(input bit undirected);
      @(posedge clock);
      csr_bus.valid      <= 1'b1;
      csr_bus.undirected <= undirected;
      do @(posedge clock);
      while (!(csr_bus.valid && csr_bus.ready));
      mode_undirected = undirected;
      csr_bus.valid <= 1'b0;
      @(negedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      graph_op_type op;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            predict_graph_op('{op: req_bus.op, src: req_bus.from_vertex,
                               dst: req_bus.to_vertex});
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (ops_pending.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
               op = ops_pending.pop_front();
               req_bus.valid       <= 1'b1;
               req_bus.op          <= op.op;
               req_bus.from_vertex <= op.src;
               req_bus.to_vertex   <= op.dst;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // response ready, with the long hold-off counted here
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_left     <= 0;
      end else begin
         if (long_hold_start) begin
            hold_left <= LONG_HOLD;
         end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
         end
         rsp_bus.ready <= !long_hold_start && hold_left <= 1
                          && $urandom_range(0, 99) >= stall_pct;
      end
   end

   // response checker
   always @(posedge clock) begin
      visit_word_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         words_checked++;
         if (visits_due.size() == 0) begin
            fail_count++;
            $display("%0t: expected no word, got vertex %0d status %0d last %0d",
                     $time, rsp_bus.vertex, rsp_bus.status, rsp_bus.last);
         end else begin
            want = visits_due.pop_front();
            if (rsp_bus.vertex !== want.vertex || rsp_bus.status !== want.status
                || rsp_bus.last !== want.last) begin
               fail_count++;
               $display("%0t: expected %0d/%0d/%0d, got %0d/%0d/%0d (vertex/status/last)",
                        $time, want.vertex, want.status, want.last,
                        rsp_bus.vertex, rsp_bus.status, rsp_bus.last);
            end
         end
      end
   end

   initial begin
      #(36_000_000);
      $display("%0t: run did not finish in time", $time);
      $display("** graph_depth_first_traversal: FAILED **");
      $finish;
   end

   initial begin
      int perm [VERTICES];
      int i, j, t, n;
      req_bus.valid       = 1'b0;
      req_bus.op          = OP_ADD_EDGE;
      req_bus.from_vertex = '0;
      req_bus.to_vertex   = '0;
      rsp_bus.ready       = 1'b0;
      csr_bus.valid       = 1'b0;
      csr_bus.undirected  = 1'b0;
      long_hold_start     = 1'b0;
      gap_pct             = 0;
      stall_pct           = 0;
      for (i = 0; i < VERTICES; i++) begin
         list_first[i] = NIL_EDGE;
         list_last[i]  = NIL_EDGE;
      end
      edge_count      = 0;
      mode_undirected = 1'b0;
      ops_accepted    = 0;
      edge_loads      = 0;
      table_full_hits = 0;
      walks           = 0;
      longest_walk    = 0;
      words_checked   = 0;
      fail_count      = 0;
      reset           = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed then undirected: empty graph, extreme vertices, insertion order, self loops
      set_mode(1'b0);
      queue_op(OP_TRAVERSE, 6'd0, 6'd63);
      queue_op(OP_TRAVERSE, 6'd63, 6'd0);
      queue_op(OP_ADD_EDGE, 6'd0, 6'd63);
      queue_op(OP_ADD_EDGE, 6'd0, 6'd1);
      queue_op(OP_ADD_EDGE, 6'd1, 6'd63);
      queue_op(OP_ADD_EDGE, 6'd63, 6'd0);
      queue_op(OP_ADD_EDGE, 6'd63, 6'd63);
      queue_op(OP_TRAVERSE, 6'd0, 6'd0);
      queue_op(OP_TRAVERSE, 6'd1, 6'd42);
      wait_drain();
      settle();
      set_mode(1'b1);
      queue_op(OP_ADD_EDGE, 6'd42, 6'd42);
      queue_op(OP_ADD_EDGE, 6'd21, 6'd42);
      queue_op(OP_ADD_EDGE, 6'd62, 6'd1);
      queue_op(OP_TRAVERSE, 6'd42, 6'd21);
      queue_op(OP_TRAVERSE, 6'd21, 6'd0);
      queue_op(OP_TRAVERSE, 6'd62, 6'd63);
      queue_op(OP_TRAVERSE, 6'd63, 6'd0);
      wait_drain();
      settle();

      // no idling: a path through every vertex gives a full-length walk
      set_mode(1'b0);
      for (i = 0; i < VERTICES; i++) perm[i] = i;
      for (i = VERTICES - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         t = perm[i];
         perm[i] = perm[j];
         perm[j] = t;
      end
      for (i = 0; i < VERTICES - 1; i++) begin
         queue_op(OP_ADD_EDGE, VERTEX_W'(perm[i]), VERTEX_W'(perm[i+1]));
      end
      queue_op(OP_TRAVERSE, VERTEX_W'(perm[0]), VERTEX_W'($urandom));
      queue_mix(50);
      wait_drain();

      // receiver holds off while walks keep coming, so the input backs up
      @(posedge clock);
      long_hold_start <= 1'b1;
      @(posedge clock);
      long_hold_start <= 1'b0;
      @(negedge clock);
      repeat (8) queue_op(OP_TRAVERSE, pick_vertex(), VERTEX_W'($urandom));
      queue_op(OP_ADD_EDGE, pick_vertex(), pick_vertex());
      queue_op(OP_TRAVERSE, pick_vertex(), VERTEX_W'($urandom));
      wait_drain();
      settle();

      set_mode(1'b1);
      gap_pct = 50;
      queue_mix(70);
      wait_drain();
      settle();

      set_mode(1'b0);
      gap_pct   = 0;
      stall_pct = 50;
      queue_mix(70);
      wait_drain();
      settle();

      // fill the pool to one free slot, then hit the table-full cases
      gap_pct   = 22;
      stall_pct = 22;
      n = EDGES - 1 - edge_count;
      for (i = 0; i < n; i++) queue_op(OP_ADD_EDGE, pick_vertex(), pick_vertex());
      wait_drain();
      settle();
      set_mode(1'b1);
      queue_op(OP_ADD_EDGE, pick_vertex(), pick_vertex());
      wait_drain();
      settle();
      set_mode(1'b0);
      queue_op(OP_ADD_EDGE, pick_vertex(), pick_vertex());
      queue_op(OP_ADD_EDGE, pick_vertex(), pick_vertex());
      queue_op(OP_TRAVERSE, pick_vertex(), VERTEX_W'($urandom));
      wait_drain();
      settle();

      set_mode(1'b1);
      queue_mix(70);
      wait_drain();
      settle();

      set_mode(1'b0);
      gap_pct   = 0;
      stall_pct = 0;
      queue_mix(40);
      wait_drain();
      settle();

      $display("%0d requests: %0d edge loads (%0d refused, pool full), %0d walks, longest %0d",
               ops_accepted, edge_loads, table_full_hits, walks, longest_walk);
      $display("%0d response words checked over both edge modes and mixed idle/stall phases",
               words_checked);
      if (fail_count == 0) begin
         $display("** graph_depth_first_traversal: PASSED **");
      end else begin
         $display("** graph_depth_first_traversal: FAILED **");
      end
      $finish;
   end

endmodule
